FILE: sv/mcledf_pkg.sv
// Shared types, field widths and codes for the multi-channel LED fader.
package mcledf_pkg;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEF   = 8;
  localparam int LEVEL_BITS_DEF = 16;

  // Stream field widths
  localparam int OP_W      = 1;
  localparam int CH_W      = 3;
  localparam int LEVEL_W   = 16;
  localparam int S_TDATA_W = 24;  // channel, target_level, zero fill
  localparam int M_TDATA_W = 24;  // channel_out, level, changed, zero fill

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FADE_W     = 16;
  localparam logic [FADE_W-1:0] FADE_STEPS_RST = 16'd100;

  // Register index, taken from paddr above the byte offset
  localparam logic REG_FADE_STEPS = 1'b0;

  // Operation codes carried in s_tuser
  localparam logic [OP_W-1:0] OP_SET  = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the accepted input transaction
    logic idx_clr;    // restart the channel walk
    logic idx_inc;    // next channel
    logic rd_set;     // read entry of the addressed channel
    logic rd_tick;    // read entry of the walk channel
    logic div_start;  // compute distance, launch divider
    logic wr_set;     // write new target and step
    logic tick_wr;    // write stepped level, load output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_ch_ok;   // channel on the input bus is in range
    logic div_busy;
    logic out_free;   // output register can take a result
    logic idx_last;   // walk is at the highest channel
  } stat_t;

endpackage

FILE: sv/multi_channel_led_fader.sv
// Multi-channel LED fader top level: stream ports, APB register, assertions.
//
//  channel   | direction | transaction carries
//  ----------+-----------+---------------------------------------------------
//  s_*       | in        | set target (tuser=0) or tick (tuser=1)
//  m_*       | out       | one result per channel on a tick, tlast on highest
//  APB       | in/out    | fade_steps at byte address 0
//
// A set transaction is paced by the one-bit-per-cycle divider. A tick
// reads and then writes each channel in turn, paced by the single read port
// of the channel store and by any stall of the output. Reset clears all
// channels to zero at once through per-channel written flags; no clearing
// pass. Input is taken again while the final result of a tick still waits
// in the output register.
module multi_channel_led_fader #(
  parameter int CHANNELS   = mcledf_pkg::CHANNELS_DEF,
  parameter int LEVEL_BITS = mcledf_pkg::LEVEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mcledf_pkg::S_TDATA_W-1:0]   s_tdata,  // [2:0] channel, [18:3] target_level
  input  logic                               s_tuser,  // [0] operation
  // master stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mcledf_pkg::M_TDATA_W-1:0]   m_tdata,  // [2:0] channel_out, [18:3] level,
                                                       // [19] changed
  output logic                               m_tlast,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcledf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mcledf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mcledf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready
);
  import mcledf_pkg::*;

  logic [FADE_W-1:0] fade_steps;
  logic              reg_sel;
  cmd_t              cmd;
  stat_t             stat;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_FADE_STEPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_steps <= FADE_STEPS_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      fade_steps <= pwdata[FADE_W-1:0];
    end
  end

  assign prdata = reg_sel ? CFG_DATA_W'(fade_steps) : '0;

  mcledf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcledf_dp #(
    .CHANNELS   (CHANNELS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .s_tdata    (s_tdata),
    .fade_steps (fade_steps),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

`ifndef SYNTHESIS
  // No new transaction while the divider works
  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !s_tready)
    else $error("input ready while divider busy");

  // Store writes only happen inside a transaction
  a_write_not_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_set || cmd.tick_wr) |-> !s_tready)
    else $error("store write while idle");

  // Last marker sits on the highest channel
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[CH_W-1:0] == CH_W'(CHANNELS - 1)))
    else $error("tlast on wrong channel");

  // A result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_wr |-> (!m_tvalid || m_tready))
    else $error("result overwritten");
`endif

endmodule

FILE: sv/mcledf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcledf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/mcledf_div.sv
// Restoring divider, one quotient bit per cycle.
module mcledf_div #(
  parameter int DVD_W = 16,
  parameter int DSR_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W:0]   trial;
  logic             fits;

  // Shift next dividend bit into the partial remainder
  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // Control: step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DSR_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DSR_W-1:0];
      end
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

FILE: sv/mcledf_dp.sv
// Fader datapath: channel store, step arithmetic, divider and output register.
module mcledf_dp #(
  parameter int CHANNELS   = mcledf_pkg::CHANNELS_DEF,
  parameter int LEVEL_BITS = mcledf_pkg::LEVEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mcledf_pkg::cmd_t                  cmd,
  output mcledf_pkg::stat_t                 stat,
  input  logic [mcledf_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [mcledf_pkg::FADE_W-1:0]     fade_steps,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mcledf_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                              m_tlast
);
  import mcledf_pkg::*;

  localparam int LW = LEVEL_BITS;
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = 3 * LW;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'((32'd1 << LW) - 32'd1);

  // Input fields
  logic [CH_W-1:0]    in_ch;
  logic [LEVEL_W-1:0] in_tgt;
  logic [LW-1:0]      in_tgt_sat;

  // Latched set transaction
  logic [CH_W-1:0] ch_q;
  logic [LW-1:0]   tgt_q;
  logic [AW-1:0]   ch_addr;

  // Channel walk
  logic [AW-1:0] idx;

  // Store access
  logic [CHANNELS-1:0] vld;
  logic                vld_rd;
  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [EW-1:0]       wr_data;
  logic [EW-1:0]       rd_data;
  logic [EW-1:0]       entry;
  logic [LW-1:0]       e_tgt;
  logic [LW-1:0]       e_lvl;
  logic [LW-1:0]       e_step;

  // Step computation
  logic [LW-1:0]     span;
  logic [LW-1:0]     dist_q;
  logic [LW-1:0]     cur_q;
  logic [LW-1:0]     quo;
  logic [LW-1:0]     step_new;
  logic [FADE_W-1:0] divisor;
  logic              div_busy;

  // Tick computation
  logic [LW-1:0] nxt;
  logic          changed;

  assign in_ch  = s_tdata[CH_W-1:0];
  assign in_tgt = s_tdata[CH_W +: LEVEL_W];

  // Saturate target into the level range
  assign in_tgt_sat = (in_tgt > LEVEL_MAX) ? LEVEL_MAX[LW-1:0] : in_tgt[LW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_q  <= in_ch;
      tgt_q <= in_tgt_sat;
    end
  end

  assign ch_addr = AW'(ch_q);

  // Channel walk counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  // Store: one entry per channel, {step, level, target}
  assign ram_re  = cmd.rd_set | cmd.rd_tick;
  assign rd_addr = cmd.rd_tick ? idx : ch_addr;
  assign ram_we  = cmd.wr_set | cmd.tick_wr;
  assign wr_addr = cmd.tick_wr ? idx : ch_addr;
  assign wr_data = cmd.tick_wr ? {e_step, nxt, e_tgt} : {step_new, cur_q, tgt_q};

  mcledf_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ram_re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Written flags: an unwritten entry reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      vld_rd <= vld[rd_addr];
    end
  end

  assign entry  = vld_rd ? rd_data : '0;
  assign e_tgt  = entry[LW-1:0];
  assign e_lvl  = entry[LW +: LW];
  assign e_step = entry[2*LW +: LW];

  // Set: distance to new target, then divide by the fade length
  assign span    = (tgt_q >= e_lvl) ? (tgt_q - e_lvl) : (e_lvl - tgt_q);
  assign divisor = (fade_steps == '0) ? FADE_W'(1) : fade_steps;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      cur_q  <= e_lvl;
      dist_q <= span;
    end
  end

  mcledf_div #(
    .DVD_W (LW),
    .DSR_W (FADE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (span),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Never let a nonzero distance stall at step zero
  assign step_new = ((dist_q != '0) && (quo == '0)) ? LW'(1) : quo;

  // Tick: move toward target without overshoot
  always_comb begin
    nxt = e_lvl;
    if (e_tgt < e_lvl) begin
      nxt = ((e_lvl - e_tgt) > e_step) ? (e_lvl - e_step) : e_tgt;
    end else if (e_tgt > e_lvl) begin
      nxt = ((e_tgt - e_lvl) > e_step) ? (e_lvl + e_step) : e_tgt;
    end
  end

  assign changed = (nxt != e_lvl);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.tick_wr) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_wr) begin
      m_tdata <= M_TDATA_W'({changed, LEVEL_W'(nxt), CH_W'(idx)});
      m_tlast <= stat.idx_last;
    end
  end

  // Status
  assign stat.in_ch_ok = (8'(in_ch) < 8'(CHANNELS));
  assign stat.div_busy = div_busy;
  assign stat.out_free = !m_tvalid || m_tready;
  assign stat.idx_last = (idx == AW'(CHANNELS - 1));

endmodule

FILE: sv/mcledf_ctrl.sv
// Fader controller: sequences set and tick transactions over the datapath.
module mcledf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tuser,
  output logic                   s_tready,
  input  mcledf_pkg::stat_t      stat,
  output mcledf_pkg::cmd_t       cmd
);
  import mcledf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_RD,
    ST_SET_START,
    ST_SET_DIV,
    ST_SET_WR,
    ST_TICK_RD,
    ST_TICK_WR
  } state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == OP_TICK) begin
              state <= ST_TICK_RD;
            end else if (stat.in_ch_ok) begin
              state <= ST_SET_RD;
            end
          end
        end
        ST_SET_RD:    state <= ST_SET_START;
        ST_SET_START: state <= ST_SET_DIV;
        ST_SET_DIV: begin
          if (!stat.div_busy) begin
            state <= ST_SET_WR;
          end
        end
        ST_SET_WR:  state <= ST_IDLE;
        ST_TICK_RD: state <= ST_TICK_WR;
        ST_TICK_WR: begin
          if (stat.out_free) begin
            state <= stat.idx_last ? ST_IDLE : ST_TICK_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.idx_clr   = accept;
    cmd.rd_set    = (state == ST_SET_RD);
    cmd.div_start = (state == ST_SET_START);
    cmd.wr_set    = (state == ST_SET_WR);
    cmd.rd_tick   = (state == ST_TICK_RD);
    cmd.tick_wr   = (state == ST_TICK_WR) && stat.out_free;
    cmd.idx_inc   = cmd.tick_wr && !stat.idx_last;
  end

endmodule
